// File: hw/rtl/jitc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON integer token checker package
// Shared types, character codes and the token arithmetic helpers.
// ----------------------------------------------------------------------------
package jitc_pkg;

  localparam logic [7:0] CharMinus     = 8'h2D;
  localparam logic [7:0] CharZero      = 8'h30;
  localparam logic [7:0] CharNine      = 8'h39;
  localparam logic [7:0] CharDot       = 8'h2E;
  localparam logic [7:0] CharExpLower  = 8'h65;
  localparam logic [7:0] CharExpUpper  = 8'h45;
  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharQuote     = 8'h22;

  localparam logic [63:0] MagLimitPos = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MagLimitNeg = 64'h8000_0000_0000_0000;
  localparam logic [4:0]  DigitCntMax = 5'd31;
  localparam logic [31:0] TokenCntMax = 32'hFFFF_FFFF;

  typedef enum logic {
    KindToken   = 1'b0,
    KindSummary = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StMalformed = 2'd1,
    StFraction  = 2'd2,
    StRange     = 2'd3
  } status_e;

  // Open number token state
  typedef struct packed {
    logic        in_num;
    logic        neg;
    logic [4:0]  dcnt;
    logic        fzero;
    logic [63:0] mag;
    logic        ovf;
  } num_t;

  typedef struct packed {
    kind_e       report_kind;
    status_e     status;
    logic [63:0] token_value;
    logic [31:0] token_count;
    logic        last_report;
  } result_t;

  // Results produced by one byte, toward the output queue
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[CharZero:CharNine]};
  endfunction

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == TokenCntMax) ? v : v + 32'd1;
  endfunction

  // mag * 10 + d, with overflow past 2^64-1 freezing the magnitude
  function automatic num_t add_digit(num_t n, logic [7:0] c);
    num_t        r;
    logic [3:0]  d;
    logic [67:0] prod;
    r = n;
    d = 4'(c - CharZero);
    if (r.dcnt != DigitCntMax) r.dcnt = r.dcnt + 5'd1;
    if (r.dcnt == 5'd1) r.fzero = (d == 4'd0);
    if (!r.ovf) begin
      prod = {1'b0, n.mag, 3'b000} + {3'b000, n.mag, 1'b0} + 68'(d);
      if (prod[67:64] != 4'd0) r.ovf = 1'b1;
      else r.mag = prod[63:0];
    end
    return r;
  endfunction

  function automatic num_t open_number(logic [7:0] c);
    num_t r;
    r        = '0;
    r.in_num = 1'b1;
    r.neg    = (c == CharMinus);
    if (!r.neg) r = add_digit(r, c);
    return r;
  endfunction

  function automatic status_e close_status(num_t n, logic has_next, logic [7:0] c);
    logic [63:0] limit;
    status_e     st;
    limit = n.neg ? MagLimitNeg : MagLimitPos;
    if (n.dcnt == 5'd0 || (n.dcnt > 5'd1 && n.fzero)) st = StMalformed;
    else if (has_next && (c inside {CharDot, CharExpLower, CharExpUpper}))
      st = StFraction;
    else if (n.ovf || n.mag > limit) st = StRange;
    else st = StOk;
    return st;
  endfunction

  function automatic logic [63:0] token_value(num_t n, status_e st);
    logic [63:0] v;
    v = 64'd0;
    if (st == StOk) v = n.neg ? (64'd0 - n.mag) : n.mag;
    return v;
  endfunction

endpackage

// File: hw/rtl/jitc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON text input channel
// Valid/ready channel carrying one text byte and the end of text mark.
// ----------------------------------------------------------------------------
interface jitc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// File: hw/rtl/jitc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Report output channel
// Valid/ready channel carrying one token report or end of text summary.
// ----------------------------------------------------------------------------
interface jitc_out_if;
  logic               valid;
  logic               ready;
  logic               report_kind;
  logic [1:0]         status;
  logic signed [63:0] token_value;
  logic [31:0]        token_count;
  logic               last_report;

  modport source (output valid, output report_kind, output status, output token_value,
                  output token_count, output last_report, input ready);
  modport sink   (input valid, input report_kind, input status, input token_value,
                  input token_count, input last_report, output ready);
endinterface

// File: hw/rtl/jitc_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte scanner
// Input register, scan state and the per-byte update that yields up to two
// reports per byte.
// ----------------------------------------------------------------------------
module jitc_scan (
  input  logic              clk_i,
  input  logic              rst_ni,
  jitc_in_if.sink           in_i,
  input  logic              space_i,
  output jitc_pkg::push_t   push_o
);

  logic                 in_valid_q;
  logic [7:0]           byte_q;
  logic                 eot_q;
  logic                 fire;

  jitc_pkg::num_t       num_q, num_d;
  logic                 str_q, str_d;
  logic                 esc_q, esc_d;
  logic                 err_q, err_d;
  jitc_pkg::status_e    ferr_q, ferr_d;
  logic [31:0]          cnt_q, cnt_d;

  jitc_pkg::result_t    res0, res1;
  logic [1:0]           n;
  logic                 consumed;
  jitc_pkg::status_e    st;

  assign fire       = in_valid_q && space_i;
  assign in_i.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.text_byte;
      eot_q  <= in_i.end_of_text;
    end
  end

  always_comb begin
    num_d    = num_q;
    str_d    = str_q;
    esc_d    = esc_q;
    err_d    = err_q;
    ferr_d   = ferr_q;
    cnt_d    = cnt_q;
    res0     = '0;
    res1     = '0;
    n        = 2'd0;
    consumed = 1'b0;
    st       = jitc_pkg::StOk;

    if (!err_q) begin
      if (num_q.in_num) begin
        if (jitc_pkg::is_digit(byte_q)) begin
          num_d    = jitc_pkg::add_digit(num_q, byte_q);
          consumed = 1'b1;
        end else begin
          st    = jitc_pkg::close_status(num_q, 1'b1, byte_q);
          cnt_d = jitc_pkg::sat_inc(cnt_d);
          res0.report_kind = jitc_pkg::KindToken;
          res0.status      = st;
          res0.token_value = jitc_pkg::token_value(num_q, st);
          res0.token_count = cnt_d;
          if (st != jitc_pkg::StOk) begin
            err_d  = 1'b1;
            ferr_d = st;
          end
          num_d    = '0;
          n        = 2'd1;
          consumed = (st != jitc_pkg::StOk);
        end
      end

      if (!consumed) begin
        if (str_d) begin
          if (esc_d) esc_d = 1'b0;
          else if (byte_q == jitc_pkg::CharBackslash) esc_d = 1'b1;
          else if (byte_q == jitc_pkg::CharQuote) str_d = 1'b0;
        end else if (byte_q == jitc_pkg::CharQuote) begin
          str_d = 1'b1;
        end else if (byte_q == jitc_pkg::CharMinus || jitc_pkg::is_digit(byte_q)) begin
          num_d = jitc_pkg::open_number(byte_q);
        end
      end

      // token still open at end of text: no following byte
      if (eot_q && num_d.in_num && !err_d) begin
        st    = jitc_pkg::close_status(num_d, 1'b0, byte_q);
        cnt_d = jitc_pkg::sat_inc(cnt_d);
        if (n == 2'd0) begin
          res0.report_kind = jitc_pkg::KindToken;
          res0.status      = st;
          res0.token_value = jitc_pkg::token_value(num_d, st);
          res0.token_count = cnt_d;
          n                = 2'd1;
        end
        if (st != jitc_pkg::StOk) begin
          err_d  = 1'b1;
          ferr_d = st;
        end
        num_d = '0;
      end
    end

    if (eot_q) begin
      if (n == 2'd0) begin
        res0.report_kind = jitc_pkg::KindSummary;
        res0.status      = err_d ? ferr_d : jitc_pkg::StOk;
        res0.token_value = 64'd0;
        res0.token_count = cnt_d;
      end else begin
        res1.report_kind = jitc_pkg::KindSummary;
        res1.status      = err_d ? ferr_d : jitc_pkg::StOk;
        res1.token_value = 64'd0;
        res1.token_count = cnt_d;
      end
      n      = n + 2'd1;
      num_d  = '0;
      str_d  = 1'b0;
      esc_d  = 1'b0;
      err_d  = 1'b0;
      ferr_d = jitc_pkg::StOk;
      cnt_d  = 32'd0;
    end

    if (n == 2'd2) res1.last_report = 1'b1;
    else if (n == 2'd1) res0.last_report = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= '0;
      str_q  <= 1'b0;
      esc_q  <= 1'b0;
      err_q  <= 1'b0;
      ferr_q <= jitc_pkg::StOk;
      cnt_q  <= 32'd0;
    end else if (fire) begin
      num_q  <= num_d;
      str_q  <= str_d;
      esc_q  <= esc_d;
      err_q  <= err_d;
      ferr_q <= ferr_d;
      cnt_q  <= cnt_d;
    end
  end

  assign push_o.cnt = fire ? n : 2'd0;
  assign push_o.r0  = res0;
  assign push_o.r1  = res1;

endmodule

// File: hw/rtl/jitc_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Report queue
// Small register queue taking up to two reports per cycle and handing out
// one per transfer on the output channel.
// ----------------------------------------------------------------------------
module jitc_out_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  jitc_pkg::push_t push_i,
  output logic            space_o,
  jitc_out_if.source      out_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);

  jitc_pkg::result_t mem_q [Depth];
  logic [AW-1:0]     wr_q, wr_d, wr_nxt, rd_q, rd_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              pop;
  jitc_pkg::result_t head;

  assign wr_nxt  = (wr_q == LastIdx) ? '0 : wr_q + AW'(1);
  assign pop     = out_o.valid && out_o.ready;
  assign space_o = (cnt_q <= CW'(Depth - 2));

  always_comb begin
    wr_d = wr_q;
    if (push_i.cnt == 2'd1) wr_d = wr_nxt;
    else if (push_i.cnt == 2'd2) wr_d = (wr_nxt == LastIdx) ? '0 : wr_nxt + AW'(1);
    rd_d = rd_q;
    if (pop) rd_d = (rd_q == LastIdx) ? '0 : rd_q + AW'(1);
    cnt_d = cnt_q + CW'(push_i.cnt) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wr_q] <= push_i.r0;
    if (push_i.cnt == 2'd2) mem_q[wr_nxt] <= push_i.r1;
  end

  assign head              = mem_q[rd_q];
  assign out_o.valid       = (cnt_q != '0);
  assign out_o.report_kind = head.report_kind;
  assign out_o.status      = head.status;
  assign out_o.token_value = head.token_value;
  assign out_o.token_count = head.token_count;
  assign out_o.last_report = head.last_report;

endmodule

// File: hw/rtl/json_integer_token_checker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON integer token checker
// Scans JSON text a byte per transfer and reports each integer token and a
// summary at the end of the text.
//
// in_i carries text_byte and end_of_text; out_o carries one report per
// transfer: a token report (report_kind 0) or the end of text summary
// (report_kind 1), last_report marking the final report caused by a byte.
// A byte causes zero, one or two reports.
// A transferred byte waits in the input register until the report queue has
// room; it is then processed and its reports are written to the queue.
// Throughput: one byte per cycle while bytes cause at most one report and
// out_o does not stall; the output channel moves one report per cycle while
// out_o is ready, so two-report bytes slow the input. The input register and
// the report queue of OutDepth entries set these figures; a byte is processed
// only when two queue slots are free.
// Reset clears the scan state, the token count, the error latch and the
// queue. When out_o stalls, reports wait in the queue and in_i keeps taking
// bytes until the queue is nearly full, then drops ready.
// ----------------------------------------------------------------------------
module json_integer_token_checker_top #(
  parameter int unsigned OutDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  jitc_in_if.sink    in_i,
  jitc_out_if.source out_o
);

  jitc_pkg::push_t push;
  logic            space;

  jitc_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .space_i (space),
    .push_o  (push)
  );

  jitc_out_fifo #(
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .out_o   (out_o)
  );

  a_summary_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.report_kind == jitc_pkg::KindSummary |-> out_o.last_report)
    else $error("summary report not marked last");

  a_summary_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.report_kind == jitc_pkg::KindSummary |-> out_o.token_value == 64'sd0)
    else $error("summary report carries a value");

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status != jitc_pkg::StOk |-> out_o.token_value == 64'sd0)
    else $error("failing token carries a value");

endmodule
